// ===== sv/sbs_pkg.sv =====
// Shared types, constants and helper functions for the sudoku solver.
`default_nettype none

package sbs_pkg;

  localparam int GRID_SIDE = 9;
  localparam int BOX_SIDE  = 3;
  localparam logic [3:0] LAST_IDX = 4'(GRID_SIDE - 1);

  typedef enum logic [1:0] {
    RD_K,
    RD_ZERO,
    RD_NEXTROW,
    RD_TRAILROW
  } rd_sel_t;

  typedef struct packed {
    logic    load_row;
    logic    sw_clr;
    logic    sw_acc;
    logic    sr_init;
    logic    fetch;
    logic    seek;
    logic    try_step;
    logic    pop;
    logic    back;
    logic    k_clr;
    logic    out_load;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic load_start;
    logic seek_found;
    logic seek_last_row;
    logic free_any;
    logic depth_zero;
    logic pop_same_row;
    logic k_last;
    logic out_xfer;
  } sts_t;

  // Box number 0..8 of a cell.
  function automatic logic [3:0] box_of(input logic [3:0] r, input logic [3:0] c);
    logic [3:0] br;
    logic [3:0] bc;
    br = (r < 4'd3) ? 4'd0 : (r < 4'd6) ? 4'd3 : 4'd6;
    bc = (c < 4'd3) ? 4'd0 : (c < 4'd6) ? 4'd1 : 4'd2;
    return br + bc;
  endfunction

  // One-hot of digit 1..9 in bits 0..8; zero for an empty cell.
  function automatic logic [8:0] dig_bit(input logic [3:0] d);
    logic [8:0] m;
    m = '0;
    for (int i = 0; i < GRID_SIDE; i++) begin
      if (d == 4'(i + 1)) m[i] = 1'b1;
    end
    return m;
  endfunction

  // Digits at or above t.
  function automatic logic [8:0] ge_mask(input logic [3:0] t);
    logic [8:0] m;
    m = '0;
    for (int i = 0; i < GRID_SIDE; i++) begin
      if (4'(i + 1) >= t) m[i] = 1'b1;
    end
    return m;
  endfunction

  // Out-of-range cell values read as empty.
  function automatic logic [3:0] clean(input logic [3:0] v);
    return (v > 4'd9) ? 4'd0 : v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sudoku_backtracking_solver.sv =====
// 9x9 sudoku solver: row loader, backtracking search and row readout.
//
// Input channel (in_valid / in_stall): one grid row per transfer, columns
// cell_a..cell_i, 0 for an empty cell, values above 9 read as empty. The row
// goes to the next grid row; final_row or the ninth row starts the search.
// Rows load one per cycle while in_stall is low.
// After the last row the block holds in_stall high while it rebuilds the
// row, column and box digit masks (each grid row read in SW_RD and added in
// SW_ACC), then searches through TRY and SEEK per placed digit and TRY, POP,
// FETCH_B (on a row change) and BACK per backtrack step, bounded by the single
// row port of the grid memory. Output channel (out_valid / out_stall): nine
// result rows in order with solved and last_out on the ninth. Each row is read
// in OUT_RD, registered in OUT_SHOW and offered in OUT_WAIT, and the next read
// waits for its transfer; out_stall holds the row in place.
// After the ninth transfer in_stall drops and the next grid may load.
// Reset (rst, synchronous) returns the block to row 0 of the load with no
// result pending; grid contents are not cleared.
`default_nettype none

module sudoku_backtracking_solver (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [3:0] cell_a,
  input  wire logic [3:0] cell_b,
  input  wire logic [3:0] cell_c,
  input  wire logic [3:0] cell_d,
  input  wire logic [3:0] cell_e,
  input  wire logic [3:0] cell_f,
  input  wire logic [3:0] cell_g,
  input  wire logic [3:0] cell_h,
  input  wire logic [3:0] cell_i,
  input  wire logic       final_row,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      out_a,
  output logic [3:0]      out_b,
  output logic [3:0]      out_c,
  output logic [3:0]      out_d,
  output logic [3:0]      out_e,
  output logic [3:0]      out_f,
  output logic [3:0]      out_g,
  output logic [3:0]      out_h,
  output logic [3:0]      out_i,
  output logic            solved,
  output logic            last_out
);

  sbs_pkg::cmd_t cmd;
  sbs_pkg::sts_t sts;
  logic [35:0]   in_row;
  logic [35:0]   out_row;

  // Pack the row, column 0 in the low nibble; drop out-of-range digits.
  assign in_row = {sbs_pkg::clean(cell_i), sbs_pkg::clean(cell_h), sbs_pkg::clean(cell_g),
                   sbs_pkg::clean(cell_f), sbs_pkg::clean(cell_e), sbs_pkg::clean(cell_d),
                   sbs_pkg::clean(cell_c), sbs_pkg::clean(cell_b), sbs_pkg::clean(cell_a)};

  // Ready only in the load state.
  assign in_stall = !cmd.load_row;

  sbs_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  sbs_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_valid),
    .in_row    (in_row),
    .in_final  (final_row),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .solved    (solved),
    .last_out  (last_out)
  );

  assign out_a = out_row[3:0];
  assign out_b = out_row[7:4];
  assign out_c = out_row[11:8];
  assign out_d = out_row[15:12];
  assign out_e = out_row[19:16];
  assign out_f = out_row[23:20];
  assign out_g = out_row[27:24];
  assign out_h = out_row[31:28];
  assign out_i = out_row[35:32];

endmodule

`default_nettype wire

// ===== sv/sbs_ctrl.sv =====
// Sequencer for load, mask sweep, backtracking search and row readout.
`default_nettype none

module sbs_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire sbs_pkg::sts_t sts,
  output sbs_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    LOAD, SW_RD, SW_ACC, SR_INIT, FETCH_S, SEEK, TRY, POP, FETCH_B, BACK,
    OUT_RD, OUT_SHOW, OUT_WAIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = sbs_pkg::RD_K;
    state_next = state;
    unique case (state)
      LOAD: begin
        cmd.load_row = 1'b1;
        if (sts.load_start) begin
          cmd.sw_clr = 1'b1;
          state_next = SW_RD;
        end
      end
      SW_RD: state_next = SW_ACC;
      SW_ACC: begin
        cmd.sw_acc = 1'b1;
        state_next = sts.k_last ? SR_INIT : SW_RD;
      end
      SR_INIT: begin
        cmd.sr_init = 1'b1;
        cmd.rd_sel  = sbs_pkg::RD_ZERO;
        state_next  = FETCH_S;
      end
      FETCH_S: begin
        cmd.fetch  = 1'b1;
        state_next = SEEK;
      end
      SEEK: begin
        cmd.seek   = 1'b1;
        cmd.rd_sel = sbs_pkg::RD_NEXTROW;
        if (sts.seek_found) begin
          state_next = TRY;
        end else if (sts.seek_last_row) begin
          cmd.k_clr  = 1'b1;
          state_next = OUT_RD;
        end else begin
          state_next = FETCH_S;
        end
      end
      TRY: begin
        cmd.try_step = 1'b1;
        if (sts.free_any) begin
          state_next = SEEK;
        end else if (sts.depth_zero) begin
          cmd.k_clr  = 1'b1;
          state_next = OUT_RD;
        end else begin
          state_next = POP;
        end
      end
      POP: begin
        cmd.pop    = 1'b1;
        cmd.rd_sel = sbs_pkg::RD_TRAILROW;
        state_next = sts.pop_same_row ? BACK : FETCH_B;
      end
      FETCH_B: begin
        cmd.fetch  = 1'b1;
        state_next = BACK;
      end
      BACK: begin
        cmd.back   = 1'b1;
        state_next = TRY;
      end
      OUT_RD: state_next = OUT_SHOW;
      OUT_SHOW: begin
        cmd.out_load = 1'b1;
        state_next   = OUT_WAIT;
      end
      OUT_WAIT: begin
        if (sts.out_xfer) state_next = sts.k_last ? LOAD : OUT_RD;
      end
      default: state_next = LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sbs_dpath.sv =====
// Grid and trail memories, constraint masks and search registers.
`default_nettype none

module sbs_dpath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sbs_pkg::cmd_t cmd,
  output sbs_pkg::sts_t      sts,
  input  wire logic          in_valid,
  input  wire logic [35:0]   in_row,
  input  wire logic          in_final,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [35:0]        out_row,
  output logic               solved,
  output logic               last_out
);

  logic [35:0] board_mem [9];
  logic [7:0]  trail_mem [81];
  logic [35:0] mem_q, rowbuf, wr_data;
  logic [7:0]  trail_q;
  logic [3:0]  rows_loaded, k, cur_r, cur_c, try_from, rd_addr, wr_addr;
  logic [6:0]  depth, trail_ra;
  logic        wr_en, in_xfer;
  logic [8:0]  rm [9];
  logic [8:0]  cm [9];
  logic [8:0]  bm [9];
  logic [8:0]  oh [9];
  logic [8:0]  rowor, used, avail;
  logic [8:0]  boxor [3];
  logic [3:0]  fcol, pick, box_cur, box_base, cur_nib;
  logic        found;

  assign in_xfer  = cmd.load_row && in_valid;
  assign box_cur  = sbs_pkg::box_of(cur_r, cur_c);
  assign box_base = sbs_pkg::box_of(k, 4'd0);
  assign cur_nib  = rowbuf[{cur_c, 2'b00} +: 4];
  assign used     = rm[cur_r] | cm[cur_c] | bm[box_cur];
  assign avail    = ~used & sbs_pkg::ge_mask(try_from);
  assign trail_ra = (depth == 7'd0) ? 7'd0 : depth - 7'd1;

  // First empty cell at or right of cur_c.
  always_comb begin
    found = 1'b0;
    fcol  = '0;
    for (int j = sbs_pkg::GRID_SIDE - 1; j >= 0; j--) begin
      if (4'(j) >= cur_c && rowbuf[4*j +: 4] == 4'd0) begin
        found = 1'b1;
        fcol  = 4'(j);
      end
    end
  end

  // Lowest free digit.
  always_comb begin
    pick = '0;
    for (int i = sbs_pkg::GRID_SIDE - 1; i >= 0; i--) begin
      if (avail[i]) pick = 4'(i + 1);
    end
  end

  always_comb begin
    rowor = '0;
    for (int j = 0; j < sbs_pkg::GRID_SIDE; j++) begin
      oh[j] = sbs_pkg::dig_bit(mem_q[4*j +: 4]);
      rowor = rowor | oh[j];
    end
    for (int b = 0; b < sbs_pkg::BOX_SIDE; b++) begin
      boxor[b] = oh[3*b] | oh[3*b+1] | oh[3*b+2];
    end
  end

  always_comb begin
    sts.load_start    = in_xfer && (in_final || rows_loaded == sbs_pkg::LAST_IDX);
    sts.seek_found    = found;
    sts.seek_last_row = (cur_r == sbs_pkg::LAST_IDX);
    sts.free_any      = (avail != 9'd0);
    sts.depth_zero    = (depth == 7'd0);
    sts.pop_same_row  = (trail_q[7:4] == cur_r);
    sts.k_last        = (k == sbs_pkg::LAST_IDX);
    sts.out_xfer      = out_valid && !out_stall;
  end

  always_comb begin
    unique case (cmd.rd_sel)
      sbs_pkg::RD_K:        rd_addr = k;
      sbs_pkg::RD_ZERO:     rd_addr = 4'd0;
      sbs_pkg::RD_NEXTROW:  rd_addr = (cur_r == sbs_pkg::LAST_IDX) ? 4'd0 : cur_r + 4'd1;
      sbs_pkg::RD_TRAILROW: rd_addr = trail_q[7:4];
      default:              rd_addr = k;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_r;
    wr_data = rowbuf;
    if (in_xfer) begin
      wr_en   = 1'b1;
      wr_addr = rows_loaded;
      wr_data = in_row;
    end else if ((cmd.seek && !found) ||
                 (cmd.try_step && !sts.free_any && sts.depth_zero) ||
                 (cmd.pop && !sts.pop_same_row)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) board_mem[wr_addr] <= wr_data;
    mem_q <= board_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.try_step && sts.free_any) trail_mem[depth] <= {cur_r, cur_c};
    trail_q <= trail_mem[trail_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (in_xfer) rows_loaded <= sts.load_start ? 4'd0 : rows_loaded + 4'd1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (sts.out_xfer) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sw_clr) begin
      k <= '0;
      for (int i = 0; i < sbs_pkg::GRID_SIDE; i++) begin
        rm[i] <= '0;
        cm[i] <= '0;
        bm[i] <= '0;
      end
    end
    if (cmd.sw_acc) begin
      k     <= k + 4'd1;
      rm[k] <= rm[k] | rowor;
      for (int j = 0; j < sbs_pkg::GRID_SIDE; j++) cm[j] <= cm[j] | oh[j];
      for (int b = 0; b < sbs_pkg::BOX_SIDE; b++) begin
        bm[box_base + 4'(b)] <= bm[box_base + 4'(b)] | boxor[b];
      end
    end
    if (cmd.sr_init) begin
      cur_r <= '0;
      cur_c <= '0;
      depth <= '0;
    end
    if (cmd.fetch) rowbuf <= mem_q;
    if (cmd.seek) begin
      if (found) begin
        cur_c    <= fcol;
        try_from <= 4'd1;
      end else if (cur_r == sbs_pkg::LAST_IDX) begin
        solved <= 1'b1;
      end else begin
        cur_r <= cur_r + 4'd1;
        cur_c <= '0;
      end
    end
    if (cmd.try_step) begin
      if (sts.free_any) begin
        rm[cur_r]   <= rm[cur_r] | sbs_pkg::dig_bit(pick);
        cm[cur_c]   <= cm[cur_c] | sbs_pkg::dig_bit(pick);
        bm[box_cur] <= bm[box_cur] | sbs_pkg::dig_bit(pick);
        rowbuf[{cur_c, 2'b00} +: 4] <= pick;
        depth <= depth + 7'd1;
        cur_c <= cur_c + 4'd1;
      end else if (sts.depth_zero) begin
        solved <= 1'b0;
      end else begin
        depth <= depth - 7'd1;
      end
    end
    if (cmd.pop) begin
      cur_r <= trail_q[7:4];
      cur_c <= trail_q[3:0];
    end
    if (cmd.back) begin
      rm[cur_r]   <= rm[cur_r] & ~sbs_pkg::dig_bit(cur_nib);
      cm[cur_c]   <= cm[cur_c] & ~sbs_pkg::dig_bit(cur_nib);
      bm[box_cur] <= bm[box_cur] & ~sbs_pkg::dig_bit(cur_nib);
      rowbuf[{cur_c, 2'b00} +: 4] <= 4'd0;
      try_from <= cur_nib + 4'd1;
    end
    if (cmd.k_clr) k <= '0;
    if (sts.out_xfer) k <= k + 4'd1;
    if (cmd.out_load) begin
      out_row  <= mem_q;
      last_out <= (k == sbs_pkg::LAST_IDX);
    end
  end

endmodule

`default_nettype wire

// ===== sv/sbs_checker.sv =====
// Port-level checks for the sudoku solver, bound to the top level.
`default_nettype none

module sbs_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic solved,
  input wire logic last_out
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // No row is taken while results are pending.
  a_no_load_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted during readout");

  // The ninth row closes the readout.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_out |=> !out_valid && !in_stall)
    else $error("readout did not end after the ninth row");

  // The solved flag is the same on every row of one grid.
  a_solved_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_out ##1 1'b1 ##1 1'b1 ##1 out_valid
    |-> $stable(solved))
    else $error("solved changed within a grid");

endmodule

bind sudoku_backtracking_solver sbs_checker u_sbs_checker (.*);

`default_nettype wire

// ===== dv/sudoku_backtracking_solver_test.sv =====
// Self-checking testbench for the backtracking sudoku solver.
`timescale 1ns / 1ps
`default_nettype none

module sudoku_backtracking_solver_test;

  localparam int CELLS = sbs_pkg::GRID_SIDE * sbs_pkg::GRID_SIDE;
  localparam int STALL_LIMIT = 400000;

  typedef struct packed {
    logic [8:0][3:0] cells;
    logic            fin;
  } grid_row_t;

  typedef struct packed {
    logic [8:0][3:0] cells;
    logic            ok;
    logic            last;
  } solved_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] cell_a = '0, cell_b = '0, cell_c = '0, cell_d = '0, cell_e = '0;
  logic [3:0] cell_f = '0, cell_g = '0, cell_h = '0, cell_i = '0;
  logic final_row = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_a, out_b, out_c, out_d, out_e, out_f, out_g, out_h, out_i;
  logic solved, last_out;

  sudoku_backtracking_solver dut (.*);

  always #6 clk = ~clk;

  // Rows waiting to be driven, and solved rows waiting to come out.
  grid_row_t   row_queue[$];
  solved_row_t solution_queue[$];
  grid_row_t   cur_row;

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int errors = 0;
  int grids_solved = 0;
  int grids_unsolvable = 0;
  int rows_sent = 0;
  int quiet_cycles = 0;

  // Shadow of the block: grid, search stack and load row.
  logic [3:0] shadow_grid [CELLS];
  int         shadow_trail [CELLS];
  int         shadow_row = 0;

  function automatic bit digit_allowed(int pos, int d);
    int r, c, br, bc;
    r = pos / 9;
    c = pos % 9;
    br = (r / 3) * 3;
    bc = (c / 3) * 3;
    for (int i = 0; i < 9; i++) begin
      if (shadow_grid[r * 9 + i] == d || shadow_grid[i * 9 + c] == d) return 1'b0;
    end
    for (int i = br; i < br + 3; i++)
      for (int j = bc; j < bc + 3; j++)
        if (shadow_grid[i * 9 + j] == d) return 1'b0;
    return 1'b1;
  endfunction

  // Depth-first fill in row-major order, digits ascending; undo on dead end.
  function automatic bit fill_grid();
    int pos, depth, d;
    bit seek;
    pos = 0;
    depth = 0;
    seek = 1'b1;
    forever begin
      if (seek) begin
        while (pos < CELLS && shadow_grid[pos] != 0) pos++;
        if (pos >= CELLS) return 1'b1;
      end
      d = int'(shadow_grid[pos]) + 1;
      shadow_grid[pos] = 4'd0;
      while (d <= 9 && !digit_allowed(pos, d)) d++;
      if (d <= 9 && depth < CELLS) begin
        shadow_grid[pos] = 4'(d);
        shadow_trail[depth] = pos;
        depth++;
        pos++;
        seek = 1'b1;
      end else begin
        if (depth == 0) return 1'b0;
        depth--;
        pos = shadow_trail[depth];
        seek = 1'b0;
      end
    end
  endfunction

  // Store one accepted row; on the last one, solve and queue nine result rows.
  function automatic void load_and_solve(grid_row_t item);
    solved_row_t res;
    bit ok;
    for (int j = 0; j < 9; j++)
      shadow_grid[shadow_row * 9 + j] = (item.cells[j] > 4'd9) ? 4'd0 : item.cells[j];
    if (!item.fin && shadow_row != 8) begin
      shadow_row++;
      return;
    end
    shadow_row = 0;
    ok = fill_grid();
    for (int k = 0; k < 9; k++) begin
      for (int j = 0; j < 9; j++) res.cells[j] = shadow_grid[k * 9 + j];
      res.ok = ok;
      res.last = (k == 8);
      solution_queue.push_back(res);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Driver: advance on each transfer, hold the payload while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        load_and_solve(cur_row);
        rows_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (row_queue.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          cur_row = row_queue.pop_front();
          {cell_i, cell_h, cell_g, cell_f, cell_e, cell_d, cell_c, cell_b, cell_a}
            <= cur_row.cells;
          final_row <= cur_row.fin;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, compare every transfer with the oldest solved row.
  always @(posedge clk) begin
    solved_row_t want;
    logic [8:0][3:0] got;
    out_stall <= ($urandom_range(99) < out_stall_pct);
    if (!rst && out_valid && !out_stall) begin
      got = {out_i, out_h, out_g, out_f, out_e, out_d, out_c, out_b, out_a};
      if (solution_queue.size() == 0) begin
        report_mismatch("unexpected result row", 1, 0);
      end else begin
        want = solution_queue.pop_front();
        for (int j = 0; j < 9; j++)
          if (got[j] !== want.cells[j])
            report_mismatch($sformatf("column %0d", j), got[j], want.cells[j]);
        if (solved !== want.ok) report_mismatch("solved", solved, want.ok);
        if (last_out !== want.last) report_mismatch("last_out", last_out, want.last);
        if (want.last) begin
          if (want.ok) grids_solved++;
          else grids_unsolvable++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  int base [CELLS];
  int pattern [CELLS];

  function automatic void shuffle(ref int a [9], input int lo, input int hi);
    int j, t;
    for (int i = hi; i > lo; i--) begin
      j = $urandom_range(i, lo);
      t = a[i]; a[i] = a[j]; a[j] = t;
    end
  endfunction

  // Fresh valid solution: shifted-row pattern with digits, rows and columns
  // permuted inside their bands and stacks.
  function automatic void new_solution();
    int dig [9], rp [9], cp [9];
    for (int i = 0; i < 9; i++) begin
      dig[i] = i + 1; rp[i] = i; cp[i] = i;
    end
    shuffle(dig, 0, 8);
    for (int b = 0; b < 3; b++) begin
      shuffle(rp, b * 3, b * 3 + 2);
      shuffle(cp, b * 3, b * 3 + 2);
    end
    for (int r = 0; r < 9; r++)
      for (int c = 0; c < 9; c++)
        base[r * 9 + c] = dig[(rp[r] * 3 + rp[r] / 3 + cp[c]) % 9];
  endfunction

  // Empty up to n random cells of the pattern; some empties are sent as 10..15.
  function automatic void punch(int n, int keep0, int keep1);
    int x;
    for (int i = 0; i < n; i++) begin
      x = $urandom_range(CELLS - 1);
      if (x != keep0 && x != keep1)
        pattern[x] = ($urandom_range(3) == 0) ? $urandom_range(15, 10) : 0;
    end
  endfunction

  // Queue rows 0..n-1 of the pattern; fin marks the last one.
  function automatic void queue_rows(int n, bit fin);
    grid_row_t item;
    for (int r = 0; r < n; r++) begin
      for (int j = 0; j < 9; j++) item.cells[j] = 4'(pattern[r * 9 + j]);
      item.fin = (r == n - 1) ? fin : 1'b0;
      row_queue.push_back(item);
    end
  endfunction

  function automatic void queue_unsolvable();
    int x, r2, c;
    new_solution();
    pattern = base;
    x = $urandom_range(CELLS - 1);
    c = x % 9;
    r2 = (x / 9 + $urandom_range(8, 1)) % 9;
    // Put the cell's own digit into its column elsewhere: nothing can fit it.
    pattern[r2 * 9 + c] = base[x];
    pattern[x] = 0;
    punch($urandom_range(6), x, r2 * 9 + c);
    queue_rows(9, $urandom_range(1));
  endfunction

  task automatic drain();
    while (row_queue.size() != 0 || in_valid || solution_queue.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int kind, start_rows;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: full grid with nothing to fill, ninth row without final_row.
    new_solution();
    pattern = base;
    queue_rows(9, 1'b0);
    // Early final_row: rewrite three rows with holes; the rest stay from before.
    punch(12, -1, -1);
    queue_rows(3, 1'b1);
    // Puzzle with a whole row sent as 15s and five holes in the middle row.
    new_solution();
    pattern = base;
    for (int j = 0; j < 9; j++) begin
      pattern[j] = 15;
      pattern[40 + j % 5] = 0;
    end
    punch(10, -1, -1);
    queue_rows(9, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 86; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 86; end
        default: begin in_idle_pct = 18; out_stall_pct = 18; end
      endcase
      start_rows = rows_sent + row_queue.size();
      if (phase == 0) queue_unsolvable();
      while (rows_sent + row_queue.size() - start_rows < 16) begin
        kind = $urandom_range(99);
        if (kind < 55) begin
          new_solution();
          pattern = base;
          punch($urandom_range(35, 1), -1, -1);
          queue_rows(9, $urandom_range(1));
        end else if (kind < 70) begin
          queue_unsolvable();
        end else if (kind < 82) begin
          // Clashing clues and no holes: returned as loaded, counted solved.
          new_solution();
          pattern = base;
          pattern[$urandom_range(CELLS - 1)] = $urandom_range(9, 1);
          queue_rows(9, $urandom_range(1));
        end else begin
          // Full grid, then a partial reload that ends early with final_row.
          new_solution();
          pattern = base;
          queue_rows(9, $urandom_range(1));
          punch($urandom_range(20, 1), -1, -1);
          queue_rows($urandom_range(8, 1), 1'b1);
        end
      end
      drain();
    end

    repeat (30) @(posedge clk);
    $display("Loaded %0d rows over four pacing phases: %0d grids solved, %0d unsolvable.",
             rows_sent, grids_solved, grids_unsolvable);
    if (errors == 0 && solution_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d rows still expected", errors, solution_queue.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/sbs_pkg.sv
sv/sbs_ctrl.sv
sv/sbs_dpath.sv
sv/sudoku_backtracking_solver.sv
sv/sbs_checker.sv
dv/sudoku_backtracking_solver_test.sv
